@@ src/gclo_pkg.sv @@
// Shared constants and types of the 3x3 grey-level closing block.
package gclo_pkg;

    // Default size limits of the line stores and row counter
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Identity values of the window reductions
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Frame size after reset
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Which slots of a 3x3 window lie inside the frame around its center
    typedef struct packed {
        logic ok;       // center is a real pixel of the frame
        logic row_lo;   // row above the center exists
        logic row_hi;   // row below the center exists
        logic col_lo;   // column left of the center exists
        logic col_hi;   // column right of the center exists
    } win_ctl_t;

    // Side information that travels with a request down the pipeline
    typedef struct packed {
        logic     row_odd;  // row parity of the next stage's line store column
        win_ctl_t ctl;      // window mask of the next stage's reduction
        logic     last;     // final closed pixel of the frame
    } side_t;

endpackage

@@ src/gclo_ctrl.sv @@
// Frame size registers, raster position counter and window coordinates.
module gclo_ctrl
    import gclo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    adv,
    input  logic                    pixel_valid,
    input  logic                    func,
    input  logic [PIX_W-1:0]        pixel_in,
    output logic                    req_valid,
    output logic [$clog2(MAX_WIDTH)-1:0] req_col,
    output logic                    req_row_odd,
    output logic                    req_wr_en,
    output logic [PIX_W-1:0]        req_data,
    output win_ctl_t                req_ctl,
    output side_t                   req_side,
    output logic [$clog2(MAX_WIDTH)-1:0] req_side_col
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 4);
    localparam int SW = RW + 1;

    localparam logic [WW-1:0] W_RST =
        WW'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
    localparam logic [HW-1:0] H_RST =
        HW'((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT);
    localparam logic signed [SW-1:0] S_ONE = 1;
    localparam logic signed [SW-1:0] S_TWO = 2;

    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;
    logic [CW-1:0] c_p_reg;
    logic [RW-1:0] r_p_reg;
    logic [CW-1:0] c_p_next;
    logic [RW-1:0] r_p_next;
    logic [CW-1:0] w_last;
    logic          w_is1;
    logic          in_pix;
    logic          pos_last;
    logic          accept;
    logic          advance;
    logic signed [SW-1:0] rp_s;
    logic signed [SW-1:0] h_s;
    logic signed [SW-1:0] r_d;
    logic signed [SW-1:0] r_e;
    logic [CW-1:0] c_d;
    logic [CW-1:0] c_e;

    // Window mask around a center at row r, column c
    function automatic win_ctl_t make_ctl(
        input logic signed [SW-1:0] r,
        input logic [CW-1:0]        c,
        input logic signed [SW-1:0] h,
        input logic [CW-1:0]        cl
    );
        win_ctl_t v;
        v.ok     = !r[SW-1] && (r < h);
        v.row_lo = (r >= S_ONE);
        v.row_hi = ((r + S_ONE) < h);
        v.col_lo = (c != '0);
        v.col_hi = (c != cl);
        return v;
    endfunction

    // Clamp written sizes into the legal range
    assign w_cfg = (cfg_data == '0) ? WW'(1) :
                   ((32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data));
    assign h_cfg = (cfg_data == '0) ? HW'(1) :
                   ((32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data));

    // Hold the frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_RST;
            h_reg <= H_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  w_reg <= w_cfg;
                REG_FRAME_HEIGHT: h_reg <= h_cfg;
                default: ;
            endcase
        end
    end

    assign w_last   = CW'(w_reg - WW'(1));
    assign w_is1    = (w_reg == WW'(1));
    assign in_pix   = (r_p_reg < RW'(h_reg));
    assign pos_last = w_is1 ? (r_p_reg == RW'(h_reg) + RW'(3))
                            : ((r_p_reg == RW'(h_reg) + RW'(2)) && (c_p_reg == CW'(1)));

    // Drop drain requests during the pixel phase; a pixel during draining acts as a drain
    assign accept  = pixel_valid && adv;
    assign advance = accept && !(func && in_pix);

    // Step the raster position, wrapping after the last drain position
    always_comb
    begin
        c_p_next = c_p_reg;
        r_p_next = r_p_reg;
        if (pos_last)
        begin
            c_p_next = '0;
            r_p_next = '0;
        end
        else if (c_p_reg == w_last)
        begin
            c_p_next = '0;
            r_p_next = r_p_reg + RW'(1);
        end
        else
        begin
            c_p_next = c_p_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_p_reg <= '0;
            r_p_reg <= '0;
        end
        else if (cfg_write)
        begin
            c_p_reg <= '0;
            r_p_reg <= '0;
        end
        else if (advance)
        begin
            c_p_reg <= c_p_next;
            r_p_reg <= r_p_next;
        end
    end

    // Locate the dilation center (width+1 behind) and erosion center (width+1 further)
    always_comb
    begin
        rp_s = $signed(SW'(r_p_reg));
        h_s  = $signed(SW'(h_reg));
        if (c_p_reg != '0)
        begin
            r_d = rp_s - S_ONE;
            c_d = c_p_reg - CW'(1);
        end
        else
        begin
            r_d = rp_s - S_TWO;
            c_d = w_last;
        end
        if (c_d != '0)
        begin
            r_e = r_d - S_ONE;
            c_e = c_d - CW'(1);
        end
        else
        begin
            r_e = r_d - S_TWO;
            c_e = w_last;
        end
    end

    // Issue the request to the dilation stage
    assign req_valid        = advance;
    assign req_col          = c_p_reg;
    assign req_row_odd      = r_p_reg[0];
    assign req_wr_en        = in_pix;
    assign req_data         = pixel_in;
    assign req_ctl          = make_ctl(r_d, c_d, h_s, w_last);
    assign req_side.row_odd = r_d[0];
    assign req_side.ctl     = make_ctl(r_e, c_e, h_s, w_last);
    assign req_side.last    = (r_e == h_s - S_ONE) && (c_e == w_last);
    assign req_side_col     = c_d;

endmodule

@@ src/gclo_stage.sv @@
// One 3x3 window stage: two-row line store, column window and masked max or min.
module gclo_stage
    import gclo_pkg::*;
#(
    parameter int   MAX_WIDTH = DEF_MAX_WIDTH,
    parameter logic TAKE_MAX  = 1'b1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    item_in,
    input  logic [$clog2(MAX_WIDTH)-1:0] col_in,
    input  logic                    row_odd,
    input  logic                    wr_en,
    input  logic [PIX_W-1:0]        wr_data,
    input  win_ctl_t                ctl_in,
    input  side_t                   side_in,
    input  logic [$clog2(MAX_WIDTH)-1:0] side_col_in,
    output logic                    item_out,
    output logic                    hit,
    output logic [PIX_W-1:0]        res,
    output side_t                   side_out,
    output logic [$clog2(MAX_WIDTH)-1:0] col_out
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [PIX_W-1:0] line_mem [DEPTH];
    logic [AW-1:0]    addr_here;
    logic [AW-1:0]    addr_prev;
    logic             mem_en;

    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;
    logic [PIX_W-1:0] bot_reg;
    logic             item_a_reg;
    win_ctl_t         ctl_reg;
    side_t            side_reg;
    logic [CW-1:0]    col_reg;

    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] res_reg;
    logic [PIX_W-1:0] res_next;
    logic             item_b_reg;
    logic             hit_reg;
    side_t            side_out_reg;
    logic [CW-1:0]    col_out_reg;
    logic [2:0]       row_m;
    logic [2:0]       col_m;

    // Row r lives in the half picked by its parity; the other half holds row r-1
    assign addr_here = {row_odd, col_in};
    assign addr_prev = {~row_odd, col_in};
    assign mem_en    = adv && item_in;

    // Read rows r-2 and r-1, then store row r over row r-2
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            top_reg <= line_mem[addr_here];
            mid_reg <= line_mem[addr_prev];
            if (wr_en)
            begin
                line_mem[addr_here] <= wr_data;
            end
        end
    end

    // Hold the request beside the memory read
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            bot_reg  <= wr_data;
            ctl_reg  <= ctl_in;
            side_reg <= side_in;
            col_reg  <= side_col_in;
        end
    end

    // Shift the new column in and reduce over the slots inside the frame
    assign row_m = {ctl_reg.row_hi, 1'b1, ctl_reg.row_lo};
    assign col_m = {ctl_reg.col_hi, 1'b1, ctl_reg.col_lo};

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i + 3];
        end
        win_next[6] = top_reg;
        win_next[7] = mid_reg;
        win_next[8] = bot_reg;
        res_next = TAKE_MAX ? PIX_MIN : PIX_MAX;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (col_m[k] && row_m[j])
                begin
                    if (TAKE_MAX ? (win_next[k*3 + j] > res_next)
                                 : (win_next[k*3 + j] < res_next))
                    begin
                        res_next = win_next[k*3 + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_a_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            res_reg      <= res_next;
            side_out_reg <= side_reg;
            col_out_reg  <= col_reg;
        end
    end

    // Advance the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_a_reg <= 1'b0;
            item_b_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (adv)
        begin
            item_a_reg <= item_in;
            item_b_reg <= item_a_reg;
            hit_reg    <= item_a_reg && ctl_reg.ok;
        end
    end

    assign item_out = item_b_reg;
    assign hit      = hit_reg;
    assign res      = res_reg;
    assign side_out = side_out_reg;
    assign col_out  = col_out_reg;

endmodule

@@ src/grey_closing_3x3.sv @@
// Top level of the streaming 3x3 grey-level closing (dilate, then erode).
//
//   channel   direction  handshake                  payload
//   pixel     in         pixel_valid / pixel_stall  func, pixel_in
//   result    out        result_valid / result_stall pixel_out, frame_last
//   config    in         cfg_write                  cfg_index, cfg_data
//
// One request per cycle while pixel_stall is low; a result passes the registers of
// both stages. Each line store does two reads and at most one write per request.
// Reset sets the frame to 640x480 at position zero; line stores are not cleared.
// A held result under result_stall freezes the whole pipeline and raises pixel_stall.
module grey_closing_3x3
    import gclo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic                 func,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic             adv;
    logic             req_valid;
    logic [CW-1:0]    req_col;
    logic             req_row_odd;
    logic             req_wr_en;
    logic [PIX_W-1:0] req_data;
    win_ctl_t         req_ctl;
    side_t            req_side;
    logic [CW-1:0]    req_side_col;

    logic             dil_item;
    logic             dil_hit;
    logic [PIX_W-1:0] dil_res;
    side_t            dil_side;
    logic [CW-1:0]    dil_col;

    logic             ero_item;
    logic             ero_hit;
    side_t            ero_side;

    // Move the pipeline whenever the result register is free or being taken
    assign adv          = !result_valid || !result_stall;
    assign pixel_stall  = !adv;
    assign result_valid = ero_item && ero_hit;
    assign frame_last   = ero_side.last;

    gclo_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .adv          (adv),
        .pixel_valid  (pixel_valid),
        .func         (func),
        .pixel_in     (pixel_in),
        .req_valid    (req_valid),
        .req_col      (req_col),
        .req_row_odd  (req_row_odd),
        .req_wr_en    (req_wr_en),
        .req_data     (req_data),
        .req_ctl      (req_ctl),
        .req_side     (req_side),
        .req_side_col (req_side_col)
    );

    // Dilation: 3x3 maximum over the input image
    gclo_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .TAKE_MAX  (1'b1)
    ) u_dilate (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_in     (req_valid),
        .col_in      (req_col),
        .row_odd     (req_row_odd),
        .wr_en       (req_wr_en),
        .wr_data     (req_data),
        .ctl_in      (req_ctl),
        .side_in     (req_side),
        .side_col_in (req_side_col),
        .item_out    (dil_item),
        .hit         (dil_hit),
        .res         (dil_res),
        .side_out    (dil_side),
        .col_out     (dil_col)
    );

    // Erosion: 3x3 minimum over the dilated image
    gclo_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .TAKE_MAX  (1'b0)
    ) u_erode (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_in     (dil_item),
        .col_in      (dil_col),
        .row_odd     (dil_side.row_odd),
        .wr_en       (dil_hit),
        .wr_data     (dil_res),
        .ctl_in      (dil_side.ctl),
        .side_in     (dil_side),
        .side_col_in (dil_col),
        .item_out    (ero_item),
        .hit         (ero_hit),
        .res         (pixel_out),
        .side_out    (ero_side),
        .col_out     ()
    );

endmodule
